/* rtl/lfk_pkg.sv */
// ----------------------------------------------------------------------------
// lfk_pkg: shared types and constants for the longest-ones-with-flips block
// Holds the payload structs, the cell control structs and default sizes.
// ----------------------------------------------------------------------------
package lfk_pkg;

    // default sizes for the top level parameters
    localparam int MAX_LEN_DEF = 65536;
    localparam int K_MAX_DEF   = 63;

    // fixed field widths
    localparam int CAP_W  = 6;   // width of max_flips and of the zero count
    localparam int BEST_W = 17;  // width of the reported length
    localparam int CAP_MAX = 63; // largest value max_flips can hold

    typedef struct packed {
        logic bit_value;
        logic seq_end;
    } lfk_in_t;

    typedef struct packed {
        logic [BEST_W-1:0] best_length;
        logic              overflow;
    } lfk_out_t;

    // per-cell control: load the new position, or take the neighbor's value
    typedef struct packed {
        logic shift;
        logic load;
    } lfk_cell_ctrl_t;

    // chain control from the window tracker
    typedef struct packed {
        logic             push;  // append at the tail, count grows
        logic             pop;   // drop the oldest and append at the tail
        logic [CAP_W-1:0] held;  // zeros currently stored
    } lfk_chain_ctrl_t;

endpackage

/* rtl/lfk_cell.sv */
// ----------------------------------------------------------------------------
// lfk_cell: one stage of the zero-position chain
// Holds one stored zero position; loads a new one or takes its neighbor's.
// ----------------------------------------------------------------------------
module lfk_cell
    import lfk_pkg::*;
#(
    parameter int POS_W = 17
) (
    input  logic             aclk,
    input  lfk_cell_ctrl_t   ctrl,
    input  logic [POS_W-1:0] new_pos,
    input  logic [POS_W-1:0] neighbor,
    output logic [POS_W-1:0] value
);

    logic [POS_W-1:0] value_reg;
    logic [POS_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            value_next = new_pos;
        end else if (ctrl.shift) begin
            value_next = neighbor;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* rtl/lfk_zero_chain.sv */
// ----------------------------------------------------------------------------
// lfk_zero_chain: row of cells forming the zero-position queue
// Cell 0 holds the oldest zero; a pop shifts every cell one step toward it.
// ----------------------------------------------------------------------------
module lfk_zero_chain
    import lfk_pkg::*;
#(
    parameter int NCELL = 63,
    parameter int POS_W = 17
) (
    input  logic             aclk,
    input  lfk_chain_ctrl_t  ctrl,
    input  logic [POS_W-1:0] new_pos,
    output logic [POS_W-1:0] head
);

    logic [POS_W-1:0] cell_val [NCELL];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        lfk_cell_ctrl_t   cc;
        logic [POS_W-1:0] nb;

        // load at the tail: index held on push, index held-1 on pop
        assign cc.load  = (ctrl.push && (ctrl.held == CAP_W'(i))) ||
                          (ctrl.pop  && (ctrl.held == CAP_W'(i + 1)));
        assign cc.shift = ctrl.pop;

        if (i == NCELL - 1) begin : g_last
            assign nb = new_pos;
        end else begin : g_mid
            assign nb = cell_val[i+1];
        end

        lfk_cell #(
            .POS_W (POS_W)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cc),
            .new_pos  (new_pos),
            .neighbor (nb),
            .value    (cell_val[i])
        );
    end

    assign head = cell_val[0];

endmodule

/* rtl/longest_ones_with_k_flips.sv */
// A result appears on m_ once its seq_end item has passed the stage 1 registers and then the output register.
// Throughput: 1 item per cycle while s_ready is high; the window tracker and the cell chain update once per item.
// The input stalls only when a finished result waits on m_ and another seq_end item
// sits in the first stage behind it.
// Reset (aresetn low, synchronous): clears sequence state, max_flips and both handshakes;
// the chain's stored positions are left as they are and are not needed after reset.
// ----------------------------------------------------------------------------
// longest_ones_with_k_flips: longest window of a bit stream with bounded zeros
// Tracks the window start with a shift-chain queue of zero positions and
// reports the best window length and an overflow flag at each sequence end.
// ----------------------------------------------------------------------------
module longest_ones_with_k_flips
    import lfk_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int K_MAX   = K_MAX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // max_flips register
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    // input stream
    input  logic             s_valid,
    output logic             s_ready,
    input  lfk_in_t          s_data,
    // results
    output logic             m_valid,
    input  logic             m_ready,
    output lfk_out_t         m_data
);

    // Only min(K_MAX, 63) zeros can ever be stored, since max_flips is 6 bits.
    localparam int NCELL = (K_MAX < CAP_MAX) ? K_MAX : CAP_MAX;
    localparam int POS_W = $clog2(MAX_LEN + 1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] max_flips_reg;
    logic [CAP_W-1:0] cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_flips_reg <= '0;
        end else if (cfg_wr_en) begin
            max_flips_reg <= cfg_wr_data;
        end
    end

    // clamp to the number of cells
    assign cap = (max_flips_reg > CAP_W'(NCELL)) ? CAP_W'(NCELL) : max_flips_reg;

    // ------------------------------------------------------------------
    // Stage 1: window tracker and zero-position chain
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] ws_reg, ws_next;
    logic [CAP_W-1:0] held_reg, held_next;
    logic             ovf_reg, ovf_next;

    logic             s1_valid_reg, s1_last_reg, s1_ovf_reg, s1_upd_reg;
    logic [POS_W-1:0] s1_len_reg;
    logic             s1_valid_next, s1_last_next, s1_ovf_next, s1_upd_next;
    logic [POS_W-1:0] s1_len_next;

    logic             s_fire;
    logic             s1_adv;
    logic             past_end;
    logic             is_zero;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] head;
    lfk_chain_ctrl_t  chain_ctrl;

    // Stage 1 moves on unless it holds a seq_end item that cannot enter the
    // output register yet.
    assign s1_adv  = !s1_valid_reg || !s1_last_reg || !m_valid || m_ready;
    assign s_ready = s1_adv;
    assign s_fire  = s_valid && s_ready;

    // items past MAX_LEN are dropped except for their seq_end mark
    assign past_end = (pos_reg == POS_W'(MAX_LEN));
    assign is_zero  = s_fire && !past_end && !s_data.bit_value;
    assign pos_inc  = pos_reg + POS_W'(1);

    always_comb begin
        chain_ctrl.held = held_reg;
        chain_ctrl.push = 1'b0;
        chain_ctrl.pop  = 1'b0;

        pos_next  = pos_reg;
        ws_next   = ws_reg;
        held_next = held_reg;
        ovf_next  = ovf_reg;

        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        s1_ovf_next   = s1_ovf_reg;
        s1_upd_next   = s1_upd_reg;
        s1_len_next   = s1_len_reg;

        if (s1_adv) begin
            s1_valid_next = s_fire;
            s1_last_next  = s_data.seq_end;
            s1_upd_next   = 1'b0;
            s1_ovf_next   = ovf_reg || past_end;
            // window length once this bit is in; the window never starts past pos+1
            s1_len_next   = pos_inc - ws_reg;
        end

        if (s_fire) begin
            if (past_end) begin
                ovf_next = 1'b1;
            end else begin
                s1_upd_next = 1'b1;
                pos_next    = pos_inc;
                if (is_zero) begin
                    priority if (held_reg < cap) begin
                        // room left: append, window start holds
                        chain_ctrl.push = 1'b1;
                        held_next       = held_reg + CAP_W'(1);
                    end else if (held_reg == '0) begin
                        // no flips allowed: restart just past this zero
                        ws_next     = pos_inc;
                        s1_len_next = '0;
                    end else begin
                        // drop the oldest zero and move the start past it
                        chain_ctrl.pop = 1'b1;
                        ws_next        = head + POS_W'(1);
                        s1_len_next    = pos_reg - head;
                    end
                end
            end

            // end of sequence: clear all tracking state
            if (s_data.seq_end) begin
                pos_next  = '0;
                ws_next   = '0;
                held_next = '0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            ws_reg       <= '0;
            held_reg     <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            ws_reg       <= ws_next;
            held_reg     <= held_next;
            ovf_reg      <= ovf_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_last_reg <= s1_last_next;
        s1_ovf_reg  <= s1_ovf_next;
        s1_upd_reg  <= s1_upd_next;
        s1_len_reg  <= s1_len_next;
    end

    lfk_zero_chain #(
        .NCELL (NCELL),
        .POS_W (POS_W)
    ) u_chain (
        .aclk    (aclk),
        .ctrl    (chain_ctrl),
        .new_pos (pos_reg),
        .head    (head)
    );

    // ------------------------------------------------------------------
    // Stage 2: running maximum and output register
    // ------------------------------------------------------------------
    logic [POS_W-1:0] best_reg, best_next;
    logic [POS_W-1:0] cand;
    logic             s2_take;
    logic             m_valid_reg, m_valid_next;
    lfk_out_t         m_data_reg, m_data_next;

    assign s2_take = s1_valid_reg && s1_adv;
    assign cand    = (s1_upd_reg && (s1_len_reg > best_reg)) ? s1_len_reg : best_reg;

    always_comb begin
        best_next    = best_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // the output transfer frees the register
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s2_take) begin
            if (s1_last_reg) begin
                // emit and restart the maximum for the next sequence
                m_valid_next            = 1'b1;
                m_data_next.best_length = BEST_W'(cand);
                m_data_next.overflow    = s1_ovf_reg;
                best_next               = '0;
            end else begin
                best_next = cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            best_reg    <= best_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CAP_W'(NCELL))
        else $error("stored zero count exceeds chain length");

    a_seq_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.seq_end) |=> (pos_reg == '0) && (held_reg == '0) && !ovf_reg)
        else $error("sequence state not cleared after end of sequence");

    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_last_reg && m_valid && !m_ready) |=>
            (s1_valid_reg && s1_last_reg && m_valid))
        else $error("blocked end-of-sequence item lost in stage 1");

    a_best_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_take && s1_last_reg) |=> (best_reg == '0) && m_valid)
        else $error("result not loaded or maximum not restarted");

    a_ws_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ws_reg <= pos_reg)
        else $error("window start beyond current position");

endmodule
